// ===== hw/rtl/mapped_region_table_macros.svh =====
// ----------------------------------------------------------------------------
// Mapped region table assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef MAPPED_REGION_TABLE_MACROS_SVH
`define MAPPED_REGION_TABLE_MACROS_SVH

// Consequence must hold in the same cycle as the antecedent.
`define MRT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define MRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/mrt_pkg.sv =====
// ----------------------------------------------------------------------------
// Mapped region table package
// Sizes, codes, and the structs shared by the controller and datapath.
// ----------------------------------------------------------------------------
package mrt_pkg;

  localparam int MAX_REGIONS = 16;
  localparam int PAGE_BITS   = 12;
  localparam int OPEN_FILES  = 16;

  localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CNT_W = $clog2(MAX_REGIONS + 1);

  localparam logic [31:0] WIN_LOW  = 32'h6000_0000;
  localparam logic [31:0] WIN_HIGH = 32'h8000_0000;
  localparam logic [7:0]  NO_FILE  = 8'hFF;

  typedef enum logic [1:0] {
    OP_MAP,
    OP_LOOKUP,
    OP_UNMAP,
    OP_QUERY
  } op_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_BAD_ADDR,
    ST_BAD_LEN,
    ST_BAD_FLAGS,
    ST_BAD_FILE,
    ST_FULL,
    ST_OVERLAP,
    ST_NOT_FOUND
  } status_t;

  typedef enum logic [1:0] {
    VAL_ZERO,
    VAL_ADDR,
    VAL_INDEX
  } vsel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_SHIFT,
    S_QREAD,
    S_FINISH
  } state_t;

  typedef struct packed {
    op_t                opcode;
    logic [31:0]        addr;
    logic signed [31:0] length;
    logic [2:0]         map_flags;
    logic [7:0]         file_desc;
    logic               file_ok;
    logic [31:0]        file_size;
    logic [3:0]         entry_index;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] result_value;
    logic [4:0]  region_count;
    logic [31:0] entry_start;
    logic [30:0] entry_length;
  } out_item_t;

  typedef struct packed {
    logic [31:0] start;
    logic [30:0] length;
    logic [2:0]  flags;
    logic [7:0]  file;
  } entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic    in_load;
    logic    ptr_clr;
    logic    scan_rd;
    logic    ptr_load_hit;
    logic    rd_query;
    logic    shift_wr;
    logic    append_wr;
    logic    cnt_dec;
    logic    out_load;
    status_t code;
    vsel_t   vsel;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    op_t     op;
    status_t pre_code;
    logic    hit;
    logic    at_end;
    logic    rd_valid;
  } dp_status_t;

endpackage

// ===== hw/rtl/mrt_dpath.sv =====
// ----------------------------------------------------------------------------
// Mapped region table datapath
// Request register, region memory, scan pointer, compare logic, result word.
// ----------------------------------------------------------------------------
`include "mapped_region_table_macros.svh"

module mrt_dpath (
  input  logic                clk,
  input  logic                rst,
  input  mrt_pkg::cmd_t       cmd,
  input  mrt_pkg::in_item_t   in_item,
  output mrt_pkg::dp_status_t st,
  output mrt_pkg::out_item_t  out_item
);

  mrt_pkg::in_item_t                item;
  mrt_pkg::entry_t                  mem [mrt_pkg::MAX_REGIONS];
  mrt_pkg::entry_t                  rdata;
  mrt_pkg::entry_t                  new_entry;
  mrt_pkg::entry_t                  wr_data;
  logic [mrt_pkg::CNT_W-1:0]        count;
  logic [mrt_pkg::CNT_W-1:0]        ptr;
  logic [mrt_pkg::IDX_W-1:0]        rd_idx;
  logic [mrt_pkg::IDX_W-1:0]        wr_addr;
  logic                             rd_valid;
  logic                             qhit;
  logic                             q_in_range;
  logic                             wr_en;
  logic [31:0]                      len_bits;
  logic [32:0]                      new_end;
  logic [32:0]                      entry_end;
  logic                             match;
  logic                             anon;
  logic                             addr_bad;
  logic                             len_bad;
  logic                             flag_bad;
  logic                             file_bad;
  logic                             full;
  mrt_pkg::status_t                 pre_code;

  // Request register, loaded when a word is accepted.
  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      item <= in_item;
    end
  end

  assign len_bits = item.length;
  assign anon     = item.map_flags[2];

  // Map request checks, in priority order.
  always_comb begin
    addr_bad = (item.addr[mrt_pkg::PAGE_BITS-1:0] != '0) ||
               (item.addr < mrt_pkg::WIN_LOW) || (item.addr >= mrt_pkg::WIN_HIGH);
    len_bad  = len_bits[31] || (len_bits == 32'd0);
    flag_bad = !(item.map_flags[0] && item.map_flags[1]);
    file_bad = !anon && (({1'b0, item.file_desc} >= 9'(mrt_pkg::OPEN_FILES)) ||
                         !item.file_ok || (len_bits > item.file_size));
    full     = (count >= mrt_pkg::CNT_W'(mrt_pkg::MAX_REGIONS));
    if (addr_bad) begin
      pre_code = mrt_pkg::ST_BAD_ADDR;
    end else if (len_bad) begin
      pre_code = mrt_pkg::ST_BAD_LEN;
    end else if (flag_bad) begin
      pre_code = mrt_pkg::ST_BAD_FLAGS;
    end else if (file_bad) begin
      pre_code = mrt_pkg::ST_BAD_FILE;
    end else if (full) begin
      pre_code = mrt_pkg::ST_FULL;
    end else begin
      pre_code = mrt_pkg::ST_OK;
    end
  end

  // Compare the entry just read against the request.
  always_comb begin
    new_end   = {1'b0, item.addr} + {1'b0, len_bits};
    entry_end = {1'b0, rdata.start} + {2'b00, rdata.length};
    case (item.opcode)
      mrt_pkg::OP_MAP: begin
        match = !((new_end <= {1'b0, rdata.start}) || ({1'b0, item.addr} >= entry_end));
      end
      mrt_pkg::OP_LOOKUP: begin
        match = (item.addr >= rdata.start) && ({1'b0, item.addr} < entry_end);
      end
      mrt_pkg::OP_UNMAP: begin
        match = (rdata.start == item.addr);
      end
      default: begin
        match = 1'b0;
      end
    endcase
  end

  assign q_in_range = (32'(item.entry_index) < 32'(count));

  // Scan pointer and read pipeline tag.
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr      <= '0;
      rd_valid <= 1'b0;
      qhit     <= 1'b0;
    end else begin
      rd_valid <= cmd.scan_rd;
      if (cmd.ptr_clr) begin
        ptr <= '0;
      end else if (cmd.ptr_load_hit) begin
        ptr <= mrt_pkg::CNT_W'(rd_idx) + 1'b1;
      end else if (cmd.scan_rd) begin
        ptr <= ptr + 1'b1;
      end
      if (cmd.in_load) begin
        qhit <= 1'b0;
      end else if (cmd.rd_query) begin
        qhit <= q_in_range;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_rd) begin
      rd_idx <= ptr[mrt_pkg::IDX_W-1:0];
    end
  end

  // Region count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.append_wr) begin
      count <= count + 1'b1;
    end else if (cmd.cnt_dec) begin
      count <= count - 1'b1;
    end
  end

  // Region memory: one write port, one registered read port.
  always_comb begin
    new_entry.start  = item.addr;
    new_entry.length = len_bits[30:0];
    new_entry.flags  = item.map_flags;
    new_entry.file   = anon ? mrt_pkg::NO_FILE : item.file_desc;
    wr_en            = cmd.append_wr || cmd.shift_wr;
    if (cmd.append_wr) begin
      wr_addr = count[mrt_pkg::IDX_W-1:0];
      wr_data = new_entry;
    end else begin
      wr_addr = mrt_pkg::IDX_W'(rd_idx - 1'b1);
      wr_data = rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_rd) begin
      rdata <= mem[ptr[mrt_pkg::IDX_W-1:0]];
    end else if (cmd.rd_query && q_in_range) begin
      rdata <= mem[mrt_pkg::IDX_W'(item.entry_index)];
    end
  end

  // Result word register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_item.status <= cmd.code;
      case (cmd.vsel)
        mrt_pkg::VAL_ADDR:  out_item.result_value <= item.addr;
        mrt_pkg::VAL_INDEX: out_item.result_value <= 32'(rd_idx);
        default:            out_item.result_value <= 32'd0;
      endcase
      out_item.region_count <= 5'(count);
      out_item.entry_start  <= qhit ? rdata.start : 32'd0;
      out_item.entry_length <= qhit ? rdata.length : 31'd0;
    end
  end

  always_comb begin
    st.op       = item.opcode;
    st.pre_code = pre_code;
    st.hit      = rd_valid && match;
    st.at_end   = (ptr >= count);
    st.rd_valid = rd_valid;
  end

  `MRT_ASSERT_IMP(a_append_room, cmd.append_wr, count < mrt_pkg::CNT_W'(mrt_pkg::MAX_REGIONS), "append into a full table")
  `MRT_ASSERT_IMP(a_dec_nonzero, cmd.cnt_dec, count != '0, "region count underflow")
  `MRT_ASSERT_IMP(a_shift_data, cmd.shift_wr, rd_valid && !cmd.append_wr, "shift write without read data")
  `MRT_ASSERT_NEXT(a_append_count, cmd.append_wr, count == mrt_pkg::CNT_W'($past(count) + 1'b1), "append did not grow the count")

endmodule

// ===== hw/rtl/mrt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Mapped region table controller
// Sequences check, scan, shift, read, and result hand-off for each request.
// ----------------------------------------------------------------------------
module mrt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  output logic                m_tvalid,
  input  logic                m_tready,
  input  mrt_pkg::dp_status_t st,
  output mrt_pkg::cmd_t       cmd
);

  mrt_pkg::state_t  state;
  mrt_pkg::state_t  state_next;
  mrt_pkg::status_t code;
  mrt_pkg::status_t code_next;
  mrt_pkg::vsel_t   vsel;
  mrt_pkg::vsel_t   vsel_next;
  logic             out_valid;
  logic             out_valid_next;

  // State, output valid and result-code registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mrt_pkg::S_IDLE;
      out_valid <= 1'b0;
      code      <= mrt_pkg::ST_OK;
      vsel      <= mrt_pkg::VAL_ZERO;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      code      <= code_next;
      vsel      <= vsel_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    code_next  = code;
    vsel_next  = vsel;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      mrt_pkg::S_IDLE: begin
        s_tready    = 1'b1;
        cmd.in_load = s_tvalid;
        if (s_tvalid) begin
          state_next = mrt_pkg::S_START;
        end
      end
      mrt_pkg::S_START: begin
        cmd.ptr_clr = 1'b1;
        code_next   = mrt_pkg::ST_OK;
        vsel_next   = mrt_pkg::VAL_ZERO;
        case (st.op)
          mrt_pkg::OP_MAP: begin
            if (st.pre_code != mrt_pkg::ST_OK) begin
              code_next  = st.pre_code;
              state_next = mrt_pkg::S_FINISH;
            end else begin
              state_next = mrt_pkg::S_SCAN;
            end
          end
          mrt_pkg::OP_QUERY: begin
            state_next = mrt_pkg::S_QREAD;
          end
          default: begin
            state_next = mrt_pkg::S_SCAN;
          end
        endcase
      end
      mrt_pkg::S_SCAN: begin
        if (st.hit) begin
          case (st.op)
            mrt_pkg::OP_MAP: begin
              code_next  = mrt_pkg::ST_OVERLAP;
              state_next = mrt_pkg::S_FINISH;
            end
            mrt_pkg::OP_LOOKUP: begin
              vsel_next  = mrt_pkg::VAL_INDEX;
              state_next = mrt_pkg::S_FINISH;
            end
            default: begin
              cmd.ptr_load_hit = 1'b1;
              state_next       = mrt_pkg::S_SHIFT;
            end
          endcase
        end else if (!st.at_end) begin
          cmd.scan_rd = 1'b1;
        end else if (!st.rd_valid) begin
          // Every held region has been compared with no match.
          if (st.op == mrt_pkg::OP_MAP) begin
            cmd.append_wr = 1'b1;
            vsel_next     = mrt_pkg::VAL_ADDR;
          end else begin
            code_next = mrt_pkg::ST_NOT_FOUND;
          end
          state_next = mrt_pkg::S_FINISH;
        end
      end
      mrt_pkg::S_SHIFT: begin
        cmd.scan_rd  = !st.at_end;
        cmd.shift_wr = st.rd_valid;
        if (st.at_end && !st.rd_valid) begin
          cmd.cnt_dec = 1'b1;
          state_next  = mrt_pkg::S_FINISH;
        end
      end
      mrt_pkg::S_QREAD: begin
        cmd.rd_query = 1'b1;
        state_next   = mrt_pkg::S_FINISH;
      end
      mrt_pkg::S_FINISH: begin
        if (!out_valid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = mrt_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = mrt_pkg::S_IDLE;
      end
    endcase
    cmd.code = code;
    cmd.vsel = vsel;
  end

  // Output word valid flag.
  always_comb begin
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  assign m_tvalid = out_valid;

endmodule

// ===== hw/rtl/mapped_region_table.sv =====
// ----------------------------------------------------------------------------
// Mapped region table
// Compacted table of mapped address regions with map, lookup, unmap and read.
// ----------------------------------------------------------------------------
// Requests are handled one at a time. A read entry request reads the indexed
// entry directly, with no scan. Map and lookup compare the stored regions in
// turn, since the regions are scanned through a single registered read port
// of the region memory; unmap scans until the matching start and then moves
// each later region down one slot through the same port. A new request word
// is taken while the previous result word still waits on the master side.
module mapped_region_table (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // addr[31:0], length[63:32], map_flags[66:64], file_desc[74:67],
  // file_ok[75], file_size[107:76], entry_index[111:108]
  input  logic [111:0] s_tdata,
  // opcode[1:0]
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // status[2:0], result_value[34:3], region_count[39:35],
  // entry_start[71:40], entry_length[102:72], zero[103]
  output logic [103:0] m_tdata
);

  mrt_pkg::in_item_t   in_item;
  mrt_pkg::out_item_t  out_item;
  mrt_pkg::cmd_t       cmd;
  mrt_pkg::dp_status_t st;

  // Unpack the request word.
  always_comb begin
    in_item.opcode      = mrt_pkg::op_t'(s_tuser);
    in_item.addr        = s_tdata[31:0];
    in_item.length      = s_tdata[63:32];
    in_item.map_flags   = s_tdata[66:64];
    in_item.file_desc   = s_tdata[74:67];
    in_item.file_ok     = s_tdata[75];
    in_item.file_size   = s_tdata[107:76];
    in_item.entry_index = s_tdata[111:108];
  end

  // Pack the result word.
  assign m_tdata = {1'b0, out_item.entry_length, out_item.entry_start,
                    out_item.region_count, out_item.result_value, out_item.status};

  mrt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .st       (st),
    .cmd      (cmd)
  );

  mrt_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_item  (in_item),
    .st       (st),
    .out_item (out_item)
  );

endmodule
